[hdl/eipl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eipl_pkg: shared types and constants of the IPv4 payload locator
// Frame size limit, header constants, status codes and the transaction
// structs of the input byte channel and the result channel.
// ----------------------------------------------------------------------------
package eipl_pkg;

  localparam int MAX_FRAME_BYTES = 16384;
  // byte counter holds 0..MAX_FRAME_BYTES
  localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
  // offsets computed from header fields may run a little past the limit
  localparam int CALC_W          = IDX_W + 1;
  localparam int FIELD_W         = 15;

  localparam int MIN_FRAME       = 42;
  localparam int ETH_TYPE_OFFSET = 12;
  localparam int TAG_BYTES       = 4;
  localparam int IP_TYPE_BYTES   = 2;
  localparam int IP_PROTO_OFFSET = 9;
  localparam int TCP_DOFF_OFFSET = 12;
  localparam int UDP_HDR_BYTES   = 8;

  localparam logic [15:0] TYPE_VLAN   = 16'h8100;
  localparam logic [15:0] TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [3:0]  IP_VERSION4 = 4'd4;

  typedef enum logic {
    PH_ETH,
    PH_IP
  } phase_t;

  typedef enum logic [3:0] {
    ST_FOUND       = 4'd0,
    ST_SHORT       = 4'd1,
    ST_NOT_IPV4    = 4'd2,
    ST_BAD_VERSION = 4'd3,
    ST_IP_TRUNC    = 4'd4,
    ST_OTHER_L4    = 4'd5,
    ST_L4_TRUNC    = 4'd6,
    ST_EMPTY       = 4'd7,
    ST_OVERSIZE    = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [FIELD_W-1:0] payload_offset;
    logic [FIELD_W-1:0] payload_length;
    logic [FIELD_W-1:0] ip_header_offset;
    logic [FIELD_W-1:0] l4_header_offset;
    logic               is_tcp;
  } out_item_t;

endpackage

[hdl/eipl_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eipl_in_stage: input register
// Holds one accepted byte transaction until the parser consumes it; takes a
// new one in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module eipl_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  eipl_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               s1_valid,
  output eipl_pkg::in_item_t s1_item
);
  import eipl_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     load;

  assign in_stall = s1_valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

[hdl/eipl_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eipl_frame_parser: per-frame header tracking and final length checks
// Updates the running header registers with each consumed byte and, on the
// last byte of a frame, forms the result from the updated values.
// ----------------------------------------------------------------------------
module eipl_frame_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  eipl_pkg::in_item_t  item,
  output eipl_pkg::out_item_t result
);
  import eipl_pkg::*;

  // running frame state
  logic [IDX_W-1:0]  idx_r,      idx_nxt;
  logic [CALC_W-1:0] tfo_r,      tfo_nxt;
  logic [15:0]       tshift_r,   tshift_nxt;
  logic [CALC_W-1:0] ip_start_r, ip_start_nxt;
  logic [3:0]        ver_r,      ver_nxt;
  logic [3:0]        ihl_r,      ihl_nxt;
  logic [7:0]        proto_r,    proto_nxt;
  logic [3:0]        doff_r,     doff_nxt;
  phase_t            phase_r,    phase_nxt;
  logic              over_r,     over_nxt;

  // state at the start of this byte (cleared on a first mark)
  logic [IDX_W-1:0]  b_idx;
  logic [CALC_W-1:0] b_tfo, b_ip_start;
  logic [15:0]       b_tshift;
  logic [3:0]        b_ver, b_ihl, b_doff;
  logic [7:0]        b_proto;
  phase_t            b_phase;
  logic              b_over;

  // state after this byte
  logic [IDX_W-1:0]  u_idx;
  logic [CALC_W-1:0] u_tfo, u_ip_start;
  logic [15:0]       u_tshift;
  logic [3:0]        u_ver, u_ihl, u_doff;
  logic [7:0]        u_proto;
  phase_t            u_phase;
  logic              u_over;

  logic [CALC_W-1:0] idx_c;
  logic              in_range;
  logic [15:0]       type_word;
  logic              at_type_lo;
  logic              type_done;

  always_comb begin
    if (item.first_of_frame) begin
      b_idx      = '0;
      b_tfo      = CALC_W'(ETH_TYPE_OFFSET);
      b_tshift   = '0;
      b_ip_start = '0;
      b_ver      = '0;
      b_ihl      = '0;
      b_proto    = '0;
      b_doff     = '0;
      b_phase    = PH_ETH;
      b_over     = 1'b0;
    end else begin
      b_idx      = idx_r;
      b_tfo      = tfo_r;
      b_tshift   = tshift_r;
      b_ip_start = ip_start_r;
      b_ver      = ver_r;
      b_ihl      = ihl_r;
      b_proto    = proto_r;
      b_doff     = doff_r;
      b_phase    = phase_r;
      b_over     = over_r;
    end
  end

  assign idx_c      = CALC_W'(b_idx);
  assign in_range   = b_idx < IDX_W'(MAX_FRAME_BYTES);
  assign type_word  = b_tshift | {8'h00, item.data_byte};
  assign at_type_lo = in_range && (b_phase == PH_ETH) && (idx_c == b_tfo + CALC_W'(1));
  assign type_done  = at_type_lo && (type_word != TYPE_VLAN);

  // phase: Ethernet/tag run until a non-tag type word completes
  always_comb begin
    u_phase = b_phase;
    if (type_done) begin
      u_phase = PH_IP;
    end
  end

  always_comb begin
    u_idx      = b_idx;
    u_tfo      = b_tfo;
    u_tshift   = b_tshift;
    u_ip_start = b_ip_start;
    u_ver      = b_ver;
    u_ihl      = b_ihl;
    u_proto    = b_proto;
    u_doff     = b_doff;
    u_over     = b_over;
    if (!in_range) begin
      u_over = 1'b1;
    end else begin
      u_idx = b_idx + IDX_W'(1);
      if (b_phase == PH_ETH) begin
        if (idx_c == b_tfo) begin
          u_tshift = {item.data_byte, 8'h00};
        end else if (at_type_lo) begin
          u_tshift = type_word;
          if (type_done) begin
            u_ip_start = b_tfo + CALC_W'(IP_TYPE_BYTES);
          end else begin
            u_tfo = b_tfo + CALC_W'(TAG_BYTES);
          end
        end
      end else begin
        if (idx_c == b_ip_start) begin
          u_ver = item.data_byte[7:4];
          u_ihl = item.data_byte[3:0];
        end
        if (idx_c == b_ip_start + CALC_W'(IP_PROTO_OFFSET)) begin
          u_proto = item.data_byte;
        end
        if (idx_c > b_ip_start &&
            idx_c == b_ip_start + CALC_W'({b_ihl, 2'b00}) + CALC_W'(TCP_DOFF_OFFSET)) begin
          u_doff = item.data_byte[7:4];
        end
      end
    end
  end

  // every frame ends with the registers back at their cleared values
  always_comb begin
    if (item.last_of_frame) begin
      idx_nxt      = '0;
      tfo_nxt      = CALC_W'(ETH_TYPE_OFFSET);
      tshift_nxt   = '0;
      ip_start_nxt = '0;
      ver_nxt      = '0;
      ihl_nxt      = '0;
      proto_nxt    = '0;
      doff_nxt     = '0;
      phase_nxt    = PH_ETH;
      over_nxt     = 1'b0;
    end else begin
      idx_nxt      = u_idx;
      tfo_nxt      = u_tfo;
      tshift_nxt   = u_tshift;
      ip_start_nxt = u_ip_start;
      ver_nxt      = u_ver;
      ihl_nxt      = u_ihl;
      proto_nxt    = u_proto;
      doff_nxt     = u_doff;
      phase_nxt    = u_phase;
      over_nxt     = u_over;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      tfo_r      <= CALC_W'(ETH_TYPE_OFFSET);
      tshift_r   <= '0;
      ip_start_r <= '0;
      ver_r      <= '0;
      ihl_r      <= '0;
      proto_r    <= '0;
      doff_r     <= '0;
      phase_r    <= PH_ETH;
      over_r     <= 1'b0;
    end else if (take) begin
      idx_r      <= idx_nxt;
      tfo_r      <= tfo_nxt;
      tshift_r   <= tshift_nxt;
      ip_start_r <= ip_start_nxt;
      ver_r      <= ver_nxt;
      ihl_r      <= ihl_nxt;
      proto_r    <= proto_nxt;
      doff_r     <= doff_nxt;
      phase_r    <= phase_nxt;
      over_r     <= over_nxt;
    end
  end

  // end-of-frame checks, in priority order
  logic [CALC_W-1:0] len;
  logic [CALC_W-1:0] l4start;
  logic [CALC_W-1:0] l4len;
  logic [CALC_W-1:0] l4end;
  logic              tcp;

  assign len     = CALC_W'(u_idx);
  assign l4start = u_ip_start + CALC_W'({u_ihl, 2'b00});
  assign tcp     = (u_proto == PROTO_TCP);
  assign l4len   = tcp ? CALC_W'({u_doff, 2'b00}) : CALC_W'(UDP_HDR_BYTES);
  assign l4end   = l4start + l4len;

  always_comb begin
    result = '0;
    if (u_over) begin
      result.status = ST_OVERSIZE;
    end else if (len < CALC_W'(MIN_FRAME)) begin
      result.status = ST_SHORT;
    end else if (u_phase == PH_ETH) begin
      // in a tag run: short only when cut right after a tag's 0x8100 word
      result.status = (len + CALC_W'(IP_TYPE_BYTES) == u_tfo) ? ST_SHORT : ST_NOT_IPV4;
    end else if (len <= u_ip_start) begin
      result.status = ST_SHORT;
    end else if (u_tshift != TYPE_IPV4) begin
      result.status = ST_NOT_IPV4;
    end else begin
      result.ip_header_offset = FIELD_W'(u_ip_start);
      if (u_ver != IP_VERSION4) begin
        result.status = ST_BAD_VERSION;
      end else if (len < l4start || u_ip_start + CALC_W'(IP_PROTO_OFFSET) >= len) begin
        result.status = ST_IP_TRUNC;
      end else if (!tcp && u_proto != PROTO_UDP) begin
        result.status           = ST_OTHER_L4;
        result.l4_header_offset = FIELD_W'(l4start);
      end else begin
        result.l4_header_offset = FIELD_W'(l4start);
        result.is_tcp           = tcp;
        if (tcp && l4start + CALC_W'(TCP_DOFF_OFFSET) >= len) begin
          result.status = ST_L4_TRUNC;
        end else if (len < l4end) begin
          result.status = ST_L4_TRUNC;
        end else if (len == l4end) begin
          result.status = ST_EMPTY;
        end else begin
          result.status         = ST_FOUND;
          result.payload_offset = FIELD_W'(l4end);
          result.payload_length = FIELD_W'(len - l4end);
        end
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.last_of_frame |=> idx_r == '0 && phase_r == PH_ETH && !over_r)
    else $error("frame state not cleared after last byte");

  a_ip_follows_type: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IP |-> ip_start_r == tfo_r + CALC_W'(IP_TYPE_BYTES))
    else $error("IP header start does not follow the type field");

  a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.last_of_frame && result.status == ST_FOUND |->
      result.payload_length != '0 && result.is_tcp == tcp)
    else $error("payload reported with zero length");

endmodule

[hdl/ethernet_ipv4_payload_locator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_ipv4_payload_locator: Ethernet/802.1Q/IPv4/TCP-UDP payload locator
// Parses a byte stream frame by frame and reports where the L4 payload sits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_item) carries one frame byte per
//   transaction with first/last marks. Any number of 802.1Q tags is skipped.
//   Output channel (out_valid/out_stall/out_item) carries one result
//   transaction per frame, issued for the byte marked last; other bytes
//   produce nothing.
//   Throughput: one byte per cycle unless a last byte waits for room in
//   the output register; the per-byte header update and the end-of-frame
//   checks fit between the input and result registers.
//   Stall: a result waits in the output register; bytes keep flowing until
//   the next last byte reaches the parser while that result is unclaimed,
//   then in_stall rises and holds until out_stall drops.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the start of a frame.
// ----------------------------------------------------------------------------
module ethernet_ipv4_payload_locator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  eipl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output eipl_pkg::out_item_t out_item
);
  import eipl_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_go;
  logic      out_free;
  logic      emit;
  out_item_t result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  eipl_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (s1_go),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // only a last byte needs room in the output register
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid && (!s1_item.last_of_frame || out_free);
  assign emit     = s1_go && s1_item.last_of_frame;

  eipl_frame_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (s1_go),
    .item   (s1_item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result raised without a last byte");

  a_mid_frame_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s1_item.last_of_frame |-> !in_stall)
    else $error("input stalled on a byte that produces no result");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && out_valid_r && out_stall)
    else $error("input stalled while output register has room");

endmodule
